// ===== sv/servo_packet_framer_defines.svh =====
// Assertion macros shared by the servo packet framer.
// No dependencies.
`ifndef SERVO_PACKET_FRAMER_DEFINES_SVH
`define SERVO_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spf_pkg.sv =====
// Types and constants for the servo packet framer.
// No dependencies; used by the controller, datapath and top level.
package spf_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] CHK_MASK   = 8'hFE;
  localparam logic [7:0] HEADER_LEN = 8'd7;

  localparam logic MODE_BEGIN   = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_RD,
    ST_LD
  } spf_state_t;

  typedef enum logic [2:0] {
    HP_SYNC0,
    HP_SYNC1,
    HP_SIZE,
    HP_ID,
    HP_CMD,
    HP_CHK1,
    HP_CHK2
  } hdr_pos_t;

  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic load_hdr;
    logic rd_en;
    logic load_pay;
  } spf_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic out_free;
    logic hdr_last;
    logic pay_empty;
    logic pay_last;
  } spf_sts_t;

endpackage

// ===== sv/spf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/spf_ctrl.sv =====
// Frame controller: sequences word intake, header emission and payload readout.
// Depends on spf_pkg.
module spf_ctrl import spf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  spf_sts_t sts,
  output spf_cmd_t cmd
);

  spf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.emit_req) begin
            cmd.idx_clr = 1'b1;
            state_next  = ST_HDR;
          end
        end
      end
      ST_HDR: begin
        if (sts.out_free) begin
          cmd.load_hdr = 1'b1;
          if (sts.hdr_last) begin
            state_next = sts.pay_empty ? ST_IDLE : ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: begin
        if (sts.out_free) begin
          cmd.load_pay = 1'b1;
          state_next   = sts.pay_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/spf_dp.sv =====
// Framer datapath: frame state, payload store, checksum and output register.
// Depends on spf_pkg and spf_ram.
module spf_dp import spf_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       mode,
  input  logic [7:0] dev_id,
  input  logic [7:0] command,
  input  logic [7:0] payload_byte,
  input  logic       last,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] tx_byte,
  output logic       end_of_frame,
  output logic       overflow,
  input  spf_cmd_t   cmd,
  output spf_sts_t   sts
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [CW-1:0] count;
  logic [7:0]    run_xor;
  logic [7:0]    held_id;
  logic [7:0]    held_cmd;
  logic          frame_open;
  logic          dropped;
  hdr_pos_t      hdr_idx;
  logic [CW-1:0] pay_idx;
  logic [CW-1:0] pay_next;
  logic          room;
  logic          store_we;
  logic [7:0]    rd_data;
  logic [7:0]    size;
  logic [7:0]    chk1;
  logic [7:0]    chk2;
  logic [7:0]    hdr_byte;

  assign room     = (count < CW'(MAX_PAYLOAD));
  assign store_we = cmd.accept && (mode == MODE_PAYLOAD) && frame_open && room;
  assign pay_next = pay_idx + CW'(1);

  assign sts.emit_req  = last && ((mode == MODE_BEGIN) || frame_open);
  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.hdr_last  = (hdr_idx == HP_CHK2);
  assign sts.pay_empty = (count == '0);
  assign sts.pay_last  = (pay_next == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      run_xor    <= '0;
      held_id    <= '0;
      held_cmd   <= '0;
      frame_open <= 1'b0;
      dropped    <= 1'b0;
    end else if (cmd.accept) begin
      if (mode == MODE_BEGIN) begin
        held_id    <= dev_id;
        held_cmd   <= command;
        count      <= '0;
        run_xor    <= '0;
        dropped    <= 1'b0;
        frame_open <= 1'b1;
      end else if (frame_open) begin
        if (room) begin
          count   <= count + CW'(1);
          run_xor <= run_xor ^ payload_byte;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (sts.emit_req) begin
        frame_open <= 1'b0;
      end
    end
  end

  spf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(count[AW-1:0]),
    .wdata(payload_byte),
    .re   (cmd.rd_en),
    .raddr(pay_idx[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx <= HP_SYNC0;
      pay_idx <= '0;
    end else if (cmd.idx_clr) begin
      hdr_idx <= HP_SYNC0;
      pay_idx <= '0;
    end else begin
      if (cmd.load_hdr && !sts.hdr_last) begin
        hdr_idx <= hdr_pos_t'(hdr_idx + 3'd1);
      end
      if (cmd.load_pay) begin
        pay_idx <= pay_next;
      end
    end
  end

  assign size = 8'(count) + HEADER_LEN;
  assign chk1 = (size ^ held_id ^ held_cmd ^ run_xor) & CHK_MASK;
  assign chk2 = (~chk1) & CHK_MASK;

  always_comb begin
    case (hdr_idx)
      HP_SYNC0: hdr_byte = SYNC_BYTE;
      HP_SYNC1: hdr_byte = SYNC_BYTE;
      HP_SIZE:  hdr_byte = size;
      HP_ID:    hdr_byte = held_id;
      HP_CMD:   hdr_byte = held_cmd;
      HP_CHK1:  hdr_byte = chk1;
      HP_CHK2:  hdr_byte = chk2;
      default:  hdr_byte = SYNC_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_hdr || cmd.load_pay) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      tx_byte      <= hdr_byte;
      end_of_frame <= sts.hdr_last && sts.pay_empty;
      overflow     <= dropped;
    end else if (cmd.load_pay) begin
      tx_byte      <= rd_data;
      end_of_frame <= sts.pay_last;
      overflow     <= dropped;
    end
  end

endmodule

// ===== sv/servo_packet_framer.sv =====
// Servo packet framer top level: controller plus datapath.
// The closing input word sends the controller to ST_HDR, which loads the first frame word.
// Input: one word per cycle while idle; stalled during emission.
// Emission: 7 header words, then each payload word by one store read then one output load
// (ST_RD, ST_LD); every load waits for the output register to be free.
// Reset: synchronous; control and frame state clear, payload store undefined.
`include "servo_packet_framer_defines.svh"
module servo_packet_framer import spf_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] dev_id,
  input  logic [7:0] command,
  input  logic [7:0] payload_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       end_of_frame,
  output logic       overflow
);

  spf_cmd_t cmd;
  spf_sts_t sts;

  spf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  spf_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .dev_id      (dev_id),
    .command     (command),
    .payload_byte(payload_byte),
    .last        (last),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .tx_byte     (tx_byte),
    .end_of_frame(end_of_frame),
    .overflow    (overflow),
    .cmd         (cmd),
    .sts         (sts)
  );

  `SPF_ASSERT_NOW(a_cmd_excl, clk, rst, 1'b1,
                  $onehot0({cmd.accept, cmd.load_hdr, cmd.rd_en, cmd.load_pay}),
                  "conflicting datapath commands")
  `SPF_ASSERT_NOW(a_load_free, clk, rst, cmd.load_hdr || cmd.load_pay,
                  !out_valid || !out_stall, "output register overwritten while held")
  `SPF_ASSERT_NEXT(a_emit_stall, clk, rst, in_valid && !in_stall && sts.emit_req,
                   in_stall, "input taken during frame emission")

endmodule
